@@ sv/assert_macros.svh @@
// Assertion macros used by the checker in md5_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define MD5_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("md5 assertion failed");

// Condition must never be true outside reset.
`define MD5_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `MD5_ASSERT(lbl, clk, rstn, !(cond))

`endif

@@ sv/md5_pkg.sv @@
// Shared types, constants and helper functions of the MD5 digest block.
// No dependencies.
package md5_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPRESS,
    ST_FOLD,
    ST_PAD80,
    ST_PADZ,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_OUT
  } md5_state_e;

  typedef enum logic [2:0] {
    SRC_INPUT,
    SRC_PAD80,
    SRC_ZERO,
    SRC_LEN_LO,
    SRC_LEN_HI
  } md5_src_e;

  typedef struct packed {
    logic       push;
    md5_src_e   src;
    logic       round;
    logic [5:0] round_idx;
    logic       fold;
    logic       restart;
    logic [1:0] out_idx;
  } md5_cmd_t;

  typedef struct packed {
    logic block_full;
    logic pad_done;
  } md5_sts_t;

  localparam logic [31:0] CHAIN_INIT [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] SINE_TABLE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_TABLE [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [4:0] rot_amount(logic [5:0] idx);
    return ROT_TABLE[{idx[5:4], idx[1:0]}];
  endfunction

  // Mask covering the low n bytes of a word; n of four or more covers all.
  function automatic logic [31:0] byte_mask(logic [2:0] n);
    logic [31:0] m;
    case (n)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

@@ sv/md5_if.sv @@
// Stream interfaces of the MD5 digest block: message input and digest output.
// Depends on nothing.
interface md5_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  byte_count;
  logic        end_of_message;

  modport source (output valid, message_word, byte_count, end_of_message, input ready);
  modport sink   (input valid, message_word, byte_count, end_of_message, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        digest_last;

  modport source (output valid, digest_word, word_index, digest_last, input ready);
  modport sink   (input valid, digest_word, word_index, digest_last, output ready);
endinterface

@@ sv/md5_ctrl.sv @@
// MD5 controller: sequences message intake, padding, 64-round compression
// and digest output. Depends on md5_pkg.
module md5_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              end_of_message_i,
  input  logic              out_ready_i,
  input  md5_pkg::md5_sts_t sts_i,
  output md5_pkg::md5_cmd_t cmd_o,
  output logic              in_ready_o,
  output logic              out_valid_o
);

  md5_pkg::md5_state_e state_q, state_d;
  md5_pkg::md5_state_e resume_q, resume_d;
  logic [5:0]          round_q, round_d;
  logic [1:0]          idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= md5_pkg::ST_IDLE;
      resume_q <= md5_pkg::ST_IDLE;
      round_q  <= '0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      resume_q <= resume_d;
      round_q  <= round_d;
      idx_q    <= idx_d;
    end
  end

  always_comb begin
    md5_pkg::md5_state_e after_push;
    after_push    = state_q;
    state_d       = state_q;
    resume_d      = resume_q;
    round_d       = round_q;
    idx_d         = idx_q;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o         = '0;
    cmd_o.src     = md5_pkg::SRC_INPUT;
    cmd_o.round_idx = round_q;
    cmd_o.out_idx = idx_q;

    case (state_q)
      md5_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.push = 1'b1;
          after_push = end_of_message_i ? md5_pkg::ST_PAD80 : md5_pkg::ST_IDLE;
        end
      end
      md5_pkg::ST_PAD80: begin
        cmd_o.push = 1'b1;
        cmd_o.src  = md5_pkg::SRC_PAD80;
        after_push = md5_pkg::ST_PADZ;
      end
      md5_pkg::ST_PADZ: begin
        if (sts_i.pad_done) begin
          state_d = md5_pkg::ST_LEN_LO;
        end else begin
          cmd_o.push = 1'b1;
          cmd_o.src  = md5_pkg::SRC_ZERO;
          after_push = md5_pkg::ST_PADZ;
        end
      end
      md5_pkg::ST_LEN_LO: begin
        cmd_o.push = 1'b1;
        cmd_o.src  = md5_pkg::SRC_LEN_LO;
        after_push = md5_pkg::ST_LEN_HI;
      end
      md5_pkg::ST_LEN_HI: begin
        cmd_o.push = 1'b1;
        cmd_o.src  = md5_pkg::SRC_LEN_HI;
        after_push = md5_pkg::ST_OUT;
      end
      md5_pkg::ST_COMPRESS: begin
        cmd_o.round = 1'b1;
        round_d     = round_q + 6'd1;
        if (round_q == 6'd63) begin
          state_d = md5_pkg::ST_FOLD;
        end
      end
      md5_pkg::ST_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d    = resume_q;
      end
      md5_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            cmd_o.restart = 1'b1;
            state_d       = md5_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = md5_pkg::ST_IDLE;
      end
    endcase

    if (cmd_o.push) begin
      if (sts_i.block_full) begin
        state_d  = md5_pkg::ST_COMPRESS;
        resume_d = after_push;
        round_d  = '0;
      end else begin
        state_d = after_push;
      end
    end
  end

endmodule

@@ sv/md5_datapath.sv @@
// MD5 datapath: byte packer, 16-word block buffer, round unit, length
// counter and chaining values. Depends on md5_pkg.
module md5_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  md5_pkg::md5_cmd_t cmd_i,
  input  logic [31:0]       message_word_i,
  input  logic [2:0]        byte_count_i,
  output md5_pkg::md5_sts_t sts_o,
  output logic [31:0]       digest_word_o
);

  logic [31:0] chain_q [4];
  logic [31:0] work_q  [4];
  logic [31:0] buf_q   [16];
  logic [31:0] stage_q;
  logic [1:0]  sb_q;
  logic [3:0]  widx_q;
  logic [63:0] bitlen_q;

  logic [31:0] push_data;
  logic [2:0]  push_cnt;
  logic [2:0]  total;
  logic [63:0] packed_w;
  logic        word_done;

  logic [1:0]  phase;
  logic [3:0]  q;
  logic [3:0]  pick;
  logic [31:0] f;
  logic [31:0] mix;
  logic [63:0] dbl;
  logic [31:0] new_b;

  // byte packer
  always_comb begin
    case (cmd_i.src)
      md5_pkg::SRC_INPUT: begin
        push_data = message_word_i;
        push_cnt  = (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;
      end
      md5_pkg::SRC_PAD80: begin
        push_data = {24'h0, md5_pkg::PAD_BYTE};
        push_cnt  = 3'd1;
      end
      md5_pkg::SRC_ZERO: begin
        push_data = '0;
        push_cnt  = 3'd4 - {1'b0, sb_q};
      end
      md5_pkg::SRC_LEN_LO: begin
        push_data = bitlen_q[31:0];
        push_cnt  = 3'd4;
      end
      md5_pkg::SRC_LEN_HI: begin
        push_data = bitlen_q[63:32];
        push_cnt  = 3'd4;
      end
      default: begin
        push_data = '0;
        push_cnt  = 3'd0;
      end
    endcase
  end

  assign total    = {1'b0, sb_q} + push_cnt;
  assign packed_w = {32'h0, stage_q & md5_pkg::byte_mask({1'b0, sb_q})}
                  | ({32'h0, push_data & md5_pkg::byte_mask(push_cnt)} << {sb_q, 3'b000});
  assign word_done = cmd_i.push && (total >= 3'd4);

  assign sts_o.block_full = word_done && (widx_q == 4'd15);
  assign sts_o.pad_done   = (widx_q == 4'd14) && (sb_q == 2'd0);

  // round unit
  assign phase = cmd_i.round_idx[5:4];
  assign q     = cmd_i.round_idx[3:0];

  always_comb begin
    case (phase)
      2'd0: begin
        f    = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
        pick = q;
      end
      2'd1: begin
        f    = (work_q[3] & work_q[1]) | (~work_q[3] & work_q[2]);
        pick = 4'(q << 2) + q + 4'd1;
      end
      2'd2: begin
        f    = work_q[1] ^ work_q[2] ^ work_q[3];
        pick = 4'(q << 1) + q + 4'd5;
      end
      default: begin
        f    = work_q[2] ^ (work_q[1] | ~work_q[3]);
        pick = 4'(q << 3) - q;
      end
    endcase
  end

  assign mix   = f + work_q[0] + md5_pkg::SINE_TABLE[cmd_i.round_idx] + buf_q[pick];
  assign dbl   = {mix, mix} << md5_pkg::rot_amount(cmd_i.round_idx);
  assign new_b = work_q[1] + dbl[63:32];

  assign digest_word_o = chain_q[cmd_i.out_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        chain_q[i] <= md5_pkg::CHAIN_INIT[i];
      end
      bitlen_q <= '0;
      sb_q     <= '0;
      widx_q   <= '0;
    end else if (cmd_i.restart) begin
      for (int i = 0; i < 4; i++) begin
        chain_q[i] <= md5_pkg::CHAIN_INIT[i];
      end
      bitlen_q <= '0;
      sb_q     <= '0;
      widx_q   <= '0;
    end else begin
      if (cmd_i.fold) begin
        for (int i = 0; i < 4; i++) begin
          chain_q[i] <= chain_q[i] + work_q[i];
        end
      end
      if (cmd_i.push) begin
        if (cmd_i.src == md5_pkg::SRC_INPUT) begin
          bitlen_q <= bitlen_q + 64'({push_cnt, 3'b000});
        end
        if (word_done) begin
          sb_q   <= 2'(total - 3'd4);
          widx_q <= widx_q + 4'd1;
        end else begin
          sb_q <= total[1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      if (word_done) begin
        buf_q[widx_q] <= packed_w[31:0];
        stage_q       <= packed_w[63:32];
      end else begin
        stage_q <= packed_w[31:0];
      end
    end
    if (sts_o.block_full) begin
      for (int i = 0; i < 4; i++) begin
        work_q[i] <= chain_q[i];
      end
    end else if (cmd_i.round) begin
      work_q[0] <= work_q[3];
      work_q[1] <= new_b;
      work_q[2] <= work_q[1];
      work_q[3] <= work_q[2];
    end
  end

endmodule

@@ sv/md5_message_digest.sv @@
// MD5 digest engine. Message words enter on in_i one transaction per cycle
// while the controller is idle (no block compression, padding or digest
// output in progress); every 64th byte starts a compression (one MD5 round per
// cycle in the shared round unit) followed by the chaining add, and no word is
// taken until it ends. On an end mark the controller steps through the padding
// (0x80 byte, zero words up to byte 56, a state that closes the zero fill, two
// length words), runs one or two further compressions, then presents the
// digest on out_o as four transactions: a, b, c, d, least significant byte
// first in message order. No new message word is taken until the fourth
// digest word is taken.
// Depends on md5_pkg, md5_if, md5_ctrl and md5_datapath.
module md5_message_digest (
  input  logic      clk_i,
  input  logic      rst_ni,
  md5_in_if.sink    in_i,
  md5_out_if.source out_o
);

  md5_pkg::md5_cmd_t cmd;
  md5_pkg::md5_sts_t sts;

  md5_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_i.valid),
    .end_of_message_i (in_i.end_of_message),
    .out_ready_i      (out_o.ready),
    .sts_i            (sts),
    .cmd_o            (cmd),
    .in_ready_o       (in_i.ready),
    .out_valid_o      (out_o.valid)
  );

  md5_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .message_word_i (in_i.message_word),
    .byte_count_i   (in_i.byte_count),
    .sts_o          (sts),
    .digest_word_o  (out_o.digest_word)
  );

  assign out_o.word_index  = cmd.out_idx;
  assign out_o.digest_last = (cmd.out_idx == 2'd3);

endmodule

@@ sv/md5_checker.sv @@
// Port-level checks of the MD5 digest engine and their bind to the top level.
// Depends on assert_macros.svh and md5_message_digest.
`include "assert_macros.svh"

module md5_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] word_index_i,
  input logic       digest_last_i
);

  logic       out_stall;
  logic       mid_fire;
  logic       last_fire;
  logic [1:0] next_index;

  assign out_stall  = out_valid_i && !out_ready_i;
  assign mid_fire   = out_valid_i && out_ready_i && !digest_last_i;
  assign last_fire  = out_valid_i && out_ready_i && digest_last_i;
  assign next_index = word_index_i + 2'd1;

  // intake is closed while a digest is presented
  `MD5_ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, out_valid_i && in_ready_i)

  `MD5_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_i && $stable(word_index_i))

  `MD5_ASSERT(a_index_step, clk_i, rst_ni, mid_fire |=> out_valid_i && word_index_i == $past(next_index))

  `MD5_ASSERT(a_last_ends, clk_i, rst_ni, last_fire |=> !out_valid_i)

endmodule

bind md5_message_digest md5_checker u_md5_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .word_index_i  (out_o.word_index),
  .digest_last_i (out_o.digest_last)
);

@@ tb/sv/md5_message_digest_tb.sv @@
// Testbench for md5_message_digest. It streams messages on the input and checks
// every digest word against an MD5 predictor kept inside the testbench.
// Depends on md5_if (md5_in_if, md5_out_if) and the md5_message_digest RTL.
`timescale 1ns / 1ps

module md5_message_digest_tb;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  index;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] ROUND_ADD [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int ROUND_SHIFT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  localparam int RANDOM_ITEMS = 350;
  localparam int DRAIN_CYCLES = 200;

  logic clk_i;
  logic rst_ni;

  md5_in_if  msg_if ();
  md5_out_if dig_if ();

  md5_message_digest i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (msg_if),
    .out_o  (dig_if)
  );

  // predictor state
  logic [31:0]  chain_word [4];
  logic [7:0]   block_bytes [64];
  logic [63:0]  message_bits;
  int unsigned  block_fill;
  digest_word_t expected_digest [$];

  int  fail_count;
  int  items_taken;
  int  messages_done;
  int  digest_checked;
  bit  burst_mode;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic void md5_restart();
    chain_word[0] = 32'h67452301;
    chain_word[1] = 32'hefcdab89;
    chain_word[2] = 32'h98badcfe;
    chain_word[3] = 32'h10325476;
    message_bits  = '0;
    block_fill    = 0;
  endfunction

  function automatic void md5_compress_block();
    logic [31:0] a, b, c, d, f, m, t;
    int g, s;
    a = chain_word[0];
    b = chain_word[1];
    c = chain_word[2];
    d = chain_word[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      m = {block_bytes[4*g+3], block_bytes[4*g+2], block_bytes[4*g+1], block_bytes[4*g]};
      t = f + a + ROUND_ADD[i] + m;
      s = ROUND_SHIFT[(i / 16) * 4 + i % 4];
      a = d;
      d = c;
      c = b;
      b = b + ((t << s) | (t >> (32 - s)));
    end
    chain_word[0] += a;
    chain_word[1] += b;
    chain_word[2] += c;
    chain_word[3] += d;
  endfunction

  function automatic void md5_push_byte(logic [7:0] value);
    block_bytes[block_fill] = value;
    block_fill++;
    if (block_fill == 64) begin
      md5_compress_block();
      block_fill = 0;
    end
  endfunction

  // counts above four saturate; an end mark pads, appends the length and emits
  function automatic void md5_absorb_word(logic [31:0] word, logic [2:0] count, logic eom);
    int unsigned  n;
    logic [63:0]  total;
    digest_word_t entry;
    n = (count > 3'd4) ? 4 : count;
    for (int k = 0; k < n; k++) begin
      md5_push_byte(word[8*k +: 8]);
      message_bits += 64'd8;
    end
    if (eom) begin
      total = message_bits;
      md5_push_byte(8'h80);
      while (block_fill != 56) md5_push_byte(8'h00);
      for (int k = 0; k < 8; k++) md5_push_byte(total[8*k +: 8]);
      for (int k = 0; k < 4; k++) begin
        entry.value = chain_word[k];
        entry.index = 2'(k);
        entry.last  = (k == 3);
        expected_digest.push_back(entry);
      end
      messages_done++;
      md5_restart();
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && msg_if.valid && msg_if.ready) begin
      if (msg_if.byte_count != 3'd0 || msg_if.end_of_message) items_taken++;
      md5_absorb_word(msg_if.message_word, msg_if.byte_count, msg_if.end_of_message);
    end
  end

  always @(posedge clk_i) begin
    digest_word_t want;
    if (rst_ni && dig_if.valid && dig_if.ready) begin
      if (expected_digest.size() == 0) begin
        $error("unexpected digest transaction: word %h index %0d", dig_if.digest_word,
               dig_if.word_index);
        fail_count++;
      end else begin
        want = expected_digest.pop_front();
        digest_checked++;
        if (dig_if.digest_word !== want.value) begin
          $error("digest_word mismatch: expected %h, actual %h", want.value,
                 dig_if.digest_word);
          fail_count++;
        end
        if (dig_if.word_index !== want.index) begin
          $error("word_index mismatch: expected %0d, actual %0d", want.index,
                 dig_if.word_index);
          fail_count++;
        end
        if (dig_if.digest_last !== want.last) begin
          $error("digest_last mismatch: expected %0b, actual %0b", want.last,
                 dig_if.digest_last);
          fail_count++;
        end
      end
    end
  end

  // digest sink backpressure
  initial begin
    dig_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      dig_if.ready <= burst_mode || ($urandom_range(0, 99) >= 29);
    end
  end

  task automatic send_word(input logic [31:0] word, input logic [2:0] count, input logic eom);
    while (!burst_mode && $urandom_range(0, 99) < 29) begin
      msg_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    msg_if.valid          <= 1'b1;
    msg_if.message_word   <= word;
    msg_if.byte_count     <= count;
    msg_if.end_of_message <= eom;
    do @(posedge clk_i); while (!msg_if.ready);
  endtask

  // hold off the sender until every outstanding digest word is back
  task automatic wait_drained();
    msg_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_digest.size() != 0);
  endtask

  task automatic test_empty_message();
    send_word(32'hdeadbeef, 3'd0, 1'b1);
    wait_drained();
  endtask

  task automatic test_known_string();
    send_word(32'h00636261, 3'd3, 1'b1);
    wait_drained();
  endtask

  task automatic test_field_extremes();
    send_word(32'hffffffff, 3'd4, 1'b0);
    send_word(32'h00000000, 3'd6, 1'b0);
    send_word(32'h5a5a5a5a, 3'd5, 1'b0);
    send_word(32'hffffffff, 3'd7, 1'b1);
    wait_drained();
  endtask

  task automatic test_short_words();
    send_word(32'ha1b2c3d4, 3'd1, 1'b0);
    send_word(32'he5f60718, 3'd2, 1'b0);
    send_word(32'h00000000, 3'd0, 1'b0);
    send_word(32'h293a4b5c, 3'd3, 1'b0);
    send_word(32'h6d7e8f90, 3'd1, 1'b1);
    wait_drained();
  endtask

  // 56 bytes: the length no longer fits, padding spills into a second block
  task automatic test_padding_spill();
    for (int k = 0; k < 14; k++)
      send_word(32'h03020100 + k * 32'h04040404, 3'd4, k == 13);
    wait_drained();
  endtask

  task automatic test_random_messages();
    int start, len, pick;
    logic [2:0] cnt;
    start = items_taken;
    while (items_taken - start < RANDOM_ITEMS) begin
      burst_mode = (items_taken - start >= 120) && (items_taken - start < 200);
      if ($urandom_range(0, 9) == 0) begin
        cnt = 3'($urandom_range(0, 7));
        send_word($urandom(), cnt, 1'($urandom_range(0, 1)));
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 6) len = $urandom_range(0, 12);
        else if (pick < 8) len = $urandom_range(13, 17);
        else len = $urandom_range(28, 34);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 11) == 0) cnt = 3'($urandom_range(0, 7));
          else cnt = 3'd4;
          send_word($urandom(), cnt, 1'b0);
        end
        if ($urandom_range(0, 7) == 0) cnt = 3'($urandom_range(5, 7));
        else cnt = 3'($urandom_range(0, 4));
        send_word($urandom(), cnt, 1'b1);
        if ($urandom_range(0, 7) == 0) wait_drained();
      end
    end
    burst_mode = 1'b0;
    send_word($urandom(), 3'd4, 1'b1);
    wait_drained();
  endtask

  initial begin
    fail_count     = 0;
    items_taken    = 0;
    messages_done  = 0;
    digest_checked = 0;
    burst_mode     = 1'b0;
    md5_restart();
    rst_ni                <= 1'b0;
    msg_if.valid          <= 1'b0;
    msg_if.message_word   <= '0;
    msg_if.byte_count     <= '0;
    msg_if.end_of_message <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_message();
    test_known_string();
    test_field_extremes();
    test_short_words();
    test_padding_spill();
    test_random_messages();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("summary: %0d message transactions, %0d messages, %0d digest words checked",
             items_taken, messages_done, digest_checked);
    $display("summary: empty, short-word, saturated-count and block-boundary messages run");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/md5_pkg.sv
sv/md5_if.sv
sv/md5_ctrl.sv
sv/md5_datapath.sv
sv/md5_message_digest.sv
sv/md5_checker.sv
tb/sv/md5_message_digest_tb.sv
